[hdl/tqv_pkg.sv]
// Shared types, constants and helpers of the tile quad vertex generator.
package tqv_pkg;

   localparam int unsigned TQV_MAX_GRID = 256;

   localparam int TW_W   = 9;   // tile width/height register width
   localparam int TPR_W  = 13;  // tiles per row register width
   localparam int SH_W   = 13;  // camera shift width
   localparam int VN_W   = 16;  // vertex number / slot width
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;
   localparam int POS_W  = 22;
   localparam int TU_W   = 21;
   localparam int TV_W   = 25;
   localparam int TILE_W = 16;
   localparam int REM_W  = 12;  // remainder is below tiles per row (<= 4096)

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TILE_WIDTH    = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TILE_HEIGHT   = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TILES_PER_ROW = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFT_X       = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFT_Y       = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_VERTEX   = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_SLOT    = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_TEXMODE_SLOT  = 4'd7;

   localparam logic [TW_W-1:0]  TILE_SIZE_RESET = 9'd16;
   localparam logic [TPR_W-1:0] TPR_RESET       = 13'd16;
   localparam logic [TW_W-1:0]  TILE_SIZE_MAX   = 9'd256;
   localparam logic [TPR_W-1:0] TPR_MAX         = 13'd4096;

   localparam logic [1:0] CORNER_LAST = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_MUL,
      ST_EMIT
   } tqv_state_type;

   typedef struct packed {
      logic load;      // request accepted
      logic div_step;  // advance the divider
      logic mul;       // capture the products
      logic emit;      // vertex taken
   } tqv_cmd_type;

   typedef struct packed {
      logic cell_skip;    // empty or off-grid cell at the request port
      logic div_last;     // final divider step this cycle
      logic corner_last;  // current vertex is the fourth
   } tqv_status_type;

   typedef struct packed {
      logic [TW_W-1:0]         tile_width;
      logic [TW_W-1:0]         tile_height;
      logic [TPR_W-1:0]        tiles_per_row;
      logic signed [SH_W-1:0]  shift_x;
      logic signed [SH_W-1:0]  shift_y;
      logic [VN_W-1:0]         base_vertex;
      logic [VN_W-1:0]         color_slot;
      logic [VN_W-1:0]         texmode_slot;
   } tqv_cfg_type;

   function automatic logic [TW_W-1:0] clamp_size(input logic [TW_W-1:0] v);
      logic [TW_W-1:0] r;
      r = v;
      if (v == '0) r = TW_W'(1);
      else if (v > TILE_SIZE_MAX) r = TILE_SIZE_MAX;
      return r;
   endfunction

   function automatic logic [TPR_W-1:0] clamp_tpr(input logic [TPR_W-1:0] v);
      logic [TPR_W-1:0] r;
      r = v;
      if (v == '0) r = TPR_W'(1);
      else if (v > TPR_MAX) r = TPR_MAX;
      return r;
   endfunction

endpackage

[hdl/tqv_div.sv]
// Iterative restoring divider, four quotient bits per cycle while step is high.
module tqv_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          step,
   input  logic [tqv_pkg::TILE_W-1:0]    dividend,
   input  logic [tqv_pkg::TPR_W-1:0]     divisor,
   output logic [tqv_pkg::TILE_W-1:0]    quotient,
   output logic [tqv_pkg::REM_W-1:0]     remainder,
   output logic                          last
);
   import tqv_pkg::*;

   localparam int BITS_PER_STEP = 4;
   localparam int CNT_W = $clog2(TILE_W / BITS_PER_STEP);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TILE_W / BITS_PER_STEP - 1);

   logic [TILE_W-1:0] quo_ff, quo_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [REM_W:0]    trial;

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      trial  = '0;
      for (int i = 0; i < BITS_PER_STEP; i++) begin
         trial  = {rem_in, quo_in[TILE_W-1]};
         quo_in = {quo_in[TILE_W-2:0], 1'b0};
         if (trial >= divisor) begin
            rem_in    = REM_W'(trial - divisor);
            quo_in[0] = 1'b1;
         end else begin
            rem_in = trial[REM_W-1:0];
         end
      end
   end

   assign cnt_in = cnt_ff + CNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= '0;
      end else if (step) begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
      end else if (step) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign last      = step && (cnt_ff == CNT_LAST);

endmodule

[hdl/tqv_dpath.sv]
// Datapath: cell capture, atlas divide, products, corner select, vertex counter.
module tqv_dpath #(
   parameter int unsigned MAX_GRID = tqv_pkg::TQV_MAX_GRID
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tqv_pkg::tqv_cfg_type                cfg,
   input  tqv_pkg::tqv_cmd_type                cmd,
   output tqv_pkg::tqv_status_type             status,
   input  logic [7:0]                          req_column,
   input  logic [7:0]                          req_grid_row,
   input  logic [tqv_pkg::TILE_W-1:0]          req_tile_number,
   input  logic                                req_rotate,
   input  logic                                req_flip,
   input  logic                                req_mirror,
   input  logic                                req_restart,
   output logic [1:0]                          rsp_corner,
   output logic signed [tqv_pkg::POS_W-1:0]    rsp_pos_x,
   output logic signed [tqv_pkg::POS_W-1:0]    rsp_pos_y,
   output logic [tqv_pkg::TU_W-1:0]            rsp_tex_u,
   output logic [tqv_pkg::TV_W-1:0]            rsp_tex_v,
   output logic [tqv_pkg::VN_W-1:0]            rsp_vertex_number,
   output logic [tqv_pkg::VN_W-1:0]            rsp_vertex_color,
   output logic [tqv_pkg::VN_W-1:0]            rsp_vertex_texmode,
   output logic                                rsp_last
);
   import tqv_pkg::*;

   logic [TW_W-1:0]   tw, th;
   logic [TPR_W-1:0]  tpr;

   logic [7:0]        col_ff, row_ff;
   logic              rot_ff, flip_ff, mir_ff;
   logic [TILE_W-1:0] quo;
   logic [REM_W-1:0]  rem;
   logic              div_last;

   logic [16:0]       xo_ff, yo_ff;   // column/row times tile size, pixels
   logic [TU_W-1:0]   u1_ff;
   logic [TV_W-1:0]   v1_ff;

   logic [1:0]        corner_ff;
   logic [VN_W-1:0]   vcnt_ff, vcnt_in;

   logic signed [POS_W-1:0] x0, x1, y0, y1;
   logic [TU_W-1:0]   u2;
   logic [TV_W-1:0]   v2;
   logic              usel, vsel;

   assign tw  = clamp_size(cfg.tile_width);
   assign th  = clamp_size(cfg.tile_height);
   assign tpr = clamp_tpr(cfg.tiles_per_row);

   assign status.cell_skip = (req_tile_number == '0)
                           || (32'(req_column) >= MAX_GRID)
                           || (32'(req_grid_row) >= MAX_GRID);
   assign status.div_last    = div_last;
   assign status.corner_last = (corner_ff == CORNER_LAST);

   tqv_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.load),
      .step      (cmd.div_step),
      .dividend  (req_tile_number - TILE_W'(1)),
      .divisor   (tpr),
      .quotient  (quo),
      .remainder (rem),
      .last      (div_last)
   );

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         col_ff  <= req_column;
         row_ff  <= req_grid_row;
         rot_ff  <= req_rotate;
         flip_ff <= req_flip;
         mir_ff  <= req_mirror;
      end
      if (cmd.mul) begin
         xo_ff <= 17'(col_ff) * 17'(tw);
         yo_ff <= 17'(row_ff) * 17'(th);
         u1_ff <= TU_W'(rem) * TU_W'(tw);
         v1_ff <= TV_W'(quo) * TV_W'(th);
      end
   end

   // corner counter and running vertex number
   always_comb begin
      vcnt_in = vcnt_ff;
      if (cmd.load && req_restart) vcnt_in = cfg.base_vertex;
      else if (cmd.emit)           vcnt_in = vcnt_ff + VN_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcnt_ff   <= '0;
         corner_ff <= '0;
      end else begin
         vcnt_ff <= vcnt_in;
         if (cmd.mul)       corner_ff <= '0;
         else if (cmd.emit) corner_ff <= corner_ff + 2'd1;
      end
   end

   // quad edges
   assign x0 = $signed({{(POS_W-SH_W){cfg.shift_x[SH_W-1]}}, cfg.shift_x})
             + $signed({1'b0, xo_ff, 4'b0000});
   assign y0 = $signed({{(POS_W-SH_W){cfg.shift_y[SH_W-1]}}, cfg.shift_y})
             + $signed({1'b0, yo_ff, 4'b0000});
   assign x1 = x0 + $signed({(POS_W-TW_W-4)'(0), tw, 4'b0000});
   assign y1 = y0 + $signed({(POS_W-TW_W-4)'(0), th, 4'b0000});
   assign u2 = u1_ff + TU_W'(tw);
   assign v2 = v1_ff + TV_W'(th);

   // rotate swaps which corner bit walks u and v; flip/mirror pick the swaps
   assign usel = (rot_ff ? corner_ff[1] : corner_ff[0]) ^ (rot_ff ? flip_ff : mir_ff);
   assign vsel = (rot_ff ? corner_ff[0] : corner_ff[1]) ^ (rot_ff ? mir_ff : flip_ff);

   assign rsp_corner         = corner_ff;
   assign rsp_pos_x          = corner_ff[0] ? x1 : x0;
   assign rsp_pos_y          = corner_ff[1] ? y1 : y0;
   assign rsp_tex_u          = usel ? u2 : u1_ff;
   assign rsp_tex_v          = vsel ? v2 : v1_ff;
   assign rsp_vertex_number  = vcnt_ff;
   assign rsp_vertex_color   = cfg.color_slot;
   assign rsp_vertex_texmode = cfg.texmode_slot;
   assign rsp_last           = status.corner_last;

endmodule

[hdl/tqv_ctrl.sv]
// Controller: sequences accept, divide, multiply and the four vertex handoffs.
module tqv_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  tqv_pkg::tqv_status_type  status,
   output tqv_pkg::tqv_cmd_type     cmd
);
   import tqv_pkg::*;

   tqv_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !status.cell_skip) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (status.div_last) state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_ready && status.corner_last) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      rsp_valid    = 1'b0;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            cmd.emit  = rsp_ready;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hdl/tile_quad_vertex_generator.sv]
// Tile quad vertex generator top level: turns each non-empty cell into four quad vertices.
// Sequence: a non-empty cell is accepted while idle, then divided (16-bit tile index
//   by tiles-per-row, 4 quotient bits a cycle), then multiplied; the four vertices
//   then follow, one vertex per cycle while rsp_ready is high.
// No new cell is taken until a quad's fourth vertex is; empty cells go at one per cycle.
// Reset: synchronous, active high; registers return to 16,16,16,0,0,0,0,0, counter to 0.
module tile_quad_vertex_generator #(
   parameter int unsigned MAX_GRID = tqv_pkg::TQV_MAX_GRID
) (
   input  logic                                clock,
   input  logic                                reset,
   // cell requests
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [7:0]                          req_column,
   input  logic [7:0]                          req_grid_row,
   input  logic [tqv_pkg::TILE_W-1:0]          req_tile_number,
   input  logic                                req_rotate,
   input  logic                                req_flip,
   input  logic                                req_mirror,
   input  logic                                req_restart,
   // vertex results
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_corner,
   output logic signed [tqv_pkg::POS_W-1:0]    rsp_pos_x,
   output logic signed [tqv_pkg::POS_W-1:0]    rsp_pos_y,
   output logic [tqv_pkg::TU_W-1:0]            rsp_tex_u,
   output logic [tqv_pkg::TV_W-1:0]            rsp_tex_v,
   output logic [tqv_pkg::VN_W-1:0]            rsp_vertex_number,
   output logic [tqv_pkg::VN_W-1:0]            rsp_vertex_color,
   output logic [tqv_pkg::VN_W-1:0]            rsp_vertex_texmode,
   output logic                                rsp_last,
   // register writes
   input  logic                                csr_write,
   input  logic [tqv_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tqv_pkg::CSR_DATA_W-1:0]      csr_data
);
   import tqv_pkg::*;

   tqv_cfg_type    cfg_ff;
   tqv_cmd_type    cmd;
   tqv_status_type status;

   // Register file. The user must make writes only while idle (not enforced here), so the
   // datapath reads the registers directly; sizes are clamped where they are used.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tile_width    <= TILE_SIZE_RESET;
         cfg_ff.tile_height   <= TILE_SIZE_RESET;
         cfg_ff.tiles_per_row <= TPR_RESET;
         cfg_ff.shift_x       <= '0;
         cfg_ff.shift_y       <= '0;
         cfg_ff.base_vertex   <= '0;
         cfg_ff.color_slot    <= '0;
         cfg_ff.texmode_slot  <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_TILE_WIDTH:    cfg_ff.tile_width    <= csr_data[TW_W-1:0];
            CSR_TILE_HEIGHT:   cfg_ff.tile_height   <= csr_data[TW_W-1:0];
            CSR_TILES_PER_ROW: cfg_ff.tiles_per_row <= csr_data[TPR_W-1:0];
            CSR_SHIFT_X:       cfg_ff.shift_x       <= csr_data[SH_W-1:0];
            CSR_SHIFT_Y:       cfg_ff.shift_y       <= csr_data[SH_W-1:0];
            CSR_BASE_VERTEX:   cfg_ff.base_vertex   <= csr_data[VN_W-1:0];
            CSR_COLOR_SLOT:    cfg_ff.color_slot    <= csr_data[VN_W-1:0];
            CSR_TEXMODE_SLOT:  cfg_ff.texmode_slot  <= csr_data[VN_W-1:0];
            default: begin
               // unknown index: write dropped
            end
         endcase
      end
   end

   tqv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tqv_dpath #(
      .MAX_GRID (MAX_GRID)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .cmd                (cmd),
      .status             (status),
      .req_column         (req_column),
      .req_grid_row       (req_grid_row),
      .req_tile_number    (req_tile_number),
      .req_rotate         (req_rotate),
      .req_flip           (req_flip),
      .req_mirror         (req_mirror),
      .req_restart        (req_restart),
      .rsp_corner         (rsp_corner),
      .rsp_pos_x          (rsp_pos_x),
      .rsp_pos_y          (rsp_pos_y),
      .rsp_tex_u          (rsp_tex_u),
      .rsp_tex_v          (rsp_tex_v),
      .rsp_vertex_number  (rsp_vertex_number),
      .rsp_vertex_color   (rsp_vertex_color),
      .rsp_vertex_texmode (rsp_vertex_texmode),
      .rsp_last           (rsp_last)
   );

endmodule

[test/tile_quad_vertex_generator_tb.sv]
// Self-checking testbench for the tile quad vertex generator: directed table, then random cells.
`timescale 1ns / 100ps

module tile_quad_vertex_generator_tb;
   import tqv_pkg::*;

   // first register index the block does not decode; writes there must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_FIRST_UNUSED = 4'd8;
   localparam int TAIL_CYCLES = 12;         // covers the wait for the first vertex, the four vertices and a margin
   localparam int RANDOM_PHASES = 8;
   localparam int CELLS_PER_PHASE = 45;
   localparam int TIMEOUT_CYCLES = 400000;

   // one grid cell as it goes into the request port
   typedef struct packed {
      logic [7:0]        column;
      logic [7:0]        grid_row;
      logic [TILE_W-1:0] tile_number;
      logic              rotate;
      logic              flip;
      logic              mirror;
      logic              restart;
   } cell_type;

   // one quad corner as it comes out of the result port
   typedef struct {
      logic [1:0]              corner;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic [TU_W-1:0]         tex_u;
      logic [TV_W-1:0]         tex_v;
      logic [VN_W-1:0]         number;
      logic [VN_W-1:0]         color;
      logic [VN_W-1:0]         texmode;
      logic                    last;
   } vertex_type;

   // directed row: a cell, plus hand-written positions and texture corners where obvious
   typedef struct {
      cell_type grid_cell;
      bit       typed;
      int       x0, x1, y0, y1;
      int       u [4];
      int       v [4];
   } stim_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [7:0]            req_column;
   logic [7:0]            req_grid_row;
   logic [TILE_W-1:0]     req_tile_number;
   logic                  req_rotate;
   logic                  req_flip;
   logic                  req_mirror;
   logic                  req_restart;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [1:0]            rsp_corner;
   logic signed [POS_W-1:0] rsp_pos_x;
   logic signed [POS_W-1:0] rsp_pos_y;
   logic [TU_W-1:0]       rsp_tex_u;
   logic [TV_W-1:0]       rsp_tex_v;
   logic [VN_W-1:0]       rsp_vertex_number;
   logic [VN_W-1:0]       rsp_vertex_color;
   logic [VN_W-1:0]       rsp_vertex_texmode;
   logic                  rsp_last;
   logic                  csr_write;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   tile_quad_vertex_generator dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_column         (req_column),
      .req_grid_row       (req_grid_row),
      .req_tile_number    (req_tile_number),
      .req_rotate         (req_rotate),
      .req_flip           (req_flip),
      .req_mirror         (req_mirror),
      .req_restart        (req_restart),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_corner         (rsp_corner),
      .rsp_pos_x          (rsp_pos_x),
      .rsp_pos_y          (rsp_pos_y),
      .rsp_tex_u          (rsp_tex_u),
      .rsp_tex_v          (rsp_tex_v),
      .rsp_vertex_number  (rsp_vertex_number),
      .rsp_vertex_color   (rsp_vertex_color),
      .rsp_vertex_texmode (rsp_vertex_texmode),
      .rsp_last           (rsp_last),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   // shadow copy of the register file and the vertex counter
   logic [TW_W-1:0]        tile_width_r;
   logic [TW_W-1:0]        tile_height_r;
   logic [TPR_W-1:0]       tiles_per_row_r;
   logic signed [SH_W-1:0] shift_x_r;
   logic signed [SH_W-1:0] shift_y_r;
   logic [VN_W-1:0]        base_vertex_r;
   logic [VN_W-1:0]        color_slot_r;
   logic [VN_W-1:0]        texmode_slot_r;
   logic [VN_W-1:0]        vertex_count;

   vertex_type   vertex_queue [$];  // corners still owed by the block, oldest first
   stim_row_type stim_table [$];
   int        err_count = 0;
   bit        calm = 0;             // no idling on either side while set
   bit        rsp_took = 0;         // a vertex was taken at the last rising edge
   int        rsp_hold = 0;
   int        scan_col = 0;
   int        scan_row = 0;

   // ------------------------------------------------------------------
   // clock and timeout
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_CYCLES * 8);
      $display("tile_quad_vertex_generator verification failed");
      $finish;
   end

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------
   function automatic void store_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_TILE_WIDTH:    tile_width_r    = data[TW_W-1:0];
         CSR_TILE_HEIGHT:   tile_height_r   = data[TW_W-1:0];
         CSR_TILES_PER_ROW: tiles_per_row_r = data[TPR_W-1:0];
         CSR_SHIFT_X:       shift_x_r       = data[SH_W-1:0];
         CSR_SHIFT_Y:       shift_y_r       = data[SH_W-1:0];
         CSR_BASE_VERTEX:   base_vertex_r   = data;
         CSR_COLOR_SLOT:    color_slot_r    = data;
         CSR_TEXMODE_SLOT:  texmode_slot_r  = data;
         default: ;         // undecoded index: dropped
      endcase
   endfunction

   // Works out the quad of one accepted cell and queues its corners; returns how many.
   function automatic int predict_quad(cell_type c);
      int unsigned tw, th, tpr, tile, u1, u2, v1, v2, swap;
      int x0, y0, x1, y1;
      int unsigned cu [4];
      int unsigned cv [4];
      vertex_type vx;
      if (c.restart) vertex_count = base_vertex_r;   // reload happens even for empty cells
      if (c.tile_number == 0 || c.column >= TQV_MAX_GRID || c.grid_row >= TQV_MAX_GRID)
         return 0;
      // out-of-range sizes saturate
      tw  = (tile_width_r == 0) ? 1 : (tile_width_r > 256) ? 256 : tile_width_r;
      th  = (tile_height_r == 0) ? 1 : (tile_height_r > 256) ? 256 : tile_height_r;
      tpr = (tiles_per_row_r == 0) ? 1 : (tiles_per_row_r > 4096) ? 4096 : tiles_per_row_r;
      tile = c.tile_number - 1;
      x0 = int'(shift_x_r) + int'(c.column * tw * 16);
      y0 = int'(shift_y_r) + int'(c.grid_row * th * 16);
      x1 = x0 + int'(tw * 16);
      y1 = y0 + int'(th * 16);
      u1 = (tile % tpr) * tw;
      v1 = (tile / tpr) * th;
      u2 = u1 + tw;
      v2 = v1 + th;
      if (c.rotate) begin
         // quarter turn: flip acts on u, mirror on v, corners walk v first
         if (c.flip) begin
            swap = u1; u1 = u2; u2 = swap;
         end
         if (c.mirror) begin
            swap = v1; v1 = v2; v2 = swap;
         end
         cu[0] = u1; cu[1] = u1; cu[2] = u2; cu[3] = u2;
         cv[0] = v1; cv[1] = v2; cv[2] = v1; cv[3] = v2;
      end else begin
         if (c.mirror) begin
            swap = u1; u1 = u2; u2 = swap;
         end
         if (c.flip) begin
            swap = v1; v1 = v2; v2 = swap;
         end
         cu[0] = u1; cu[1] = u2; cu[2] = u1; cu[3] = u2;
         cv[0] = v1; cv[1] = v1; cv[2] = v2; cv[3] = v2;
      end
      for (int k = 0; k < 4; k++) begin
         vx.corner  = 2'(k);
         vx.pos_x   = POS_W'((k & 1) ? x1 : x0);
         vx.pos_y   = POS_W'((k & 2) ? y1 : y0);
         vx.tex_u   = TU_W'(cu[k]);
         vx.tex_v   = TV_W'(cv[k]);
         vx.number  = vertex_count;
         vx.color   = color_slot_r;
         vx.texmode = texmode_slot_r;
         vx.last    = (vx.corner == CORNER_LAST);
         vertex_count = vertex_count + 1'b1;          // wraps at 16 bits
         vertex_queue = {vertex_queue, vx};
      end
      return 4;
   endfunction

   // ------------------------------------------------------------------
   // result side: checker at the rising edge, back-pressure at the falling edge
   // ------------------------------------------------------------------
   function automatic void check_field(string name, longint want, longint got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         err_count++;
      end
   endfunction

   always @(posedge clock) begin
      vertex_type want;
      rsp_took = 1'b0;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_took = 1'b1;
         if (vertex_queue.size() == 0) begin
            $error("vertex with no request pending: corner %0d number %0d",
                   rsp_corner, rsp_vertex_number);
            err_count++;
         end else begin
            want = vertex_queue.pop_front();
            check_field("corner",         want.corner,  rsp_corner);
            check_field("pos_x",          want.pos_x,   rsp_pos_x);
            check_field("pos_y",          want.pos_y,   rsp_pos_y);
            check_field("tex_u",          want.tex_u,   rsp_tex_u);
            check_field("tex_v",          want.tex_v,   rsp_tex_v);
            check_field("vertex_number",  want.number,  rsp_vertex_number);
            check_field("vertex_color",   want.color,   rsp_vertex_color);
            check_field("vertex_texmode", want.texmode, rsp_vertex_texmode);
            check_field("last",           want.last,    rsp_last);
         end
      end
   end

   function automatic int draw_wait();
      return calm ? 0 : $urandom_range(0, 17);
   endfunction

   // after each taken vertex, drop ready for a random number of cycles
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_hold > 0) begin
            rsp_hold = rsp_hold - 1;
            if (rsp_hold == 0) rsp_ready <= 1'b1;
         end else if (rsp_took) begin
            rsp_hold = draw_wait();
            if (rsp_hold > 0) rsp_ready <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------
   // Entered and left at a falling edge. Valid stays up across back-to-back requests.
   task automatic send_cell(stim_row_type row);
      int gap;
      int n;
      int at;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_column      <= row.grid_cell.column;
      req_grid_row    <= row.grid_cell.grid_row;
      req_tile_number <= row.grid_cell.tile_number;
      req_rotate      <= row.grid_cell.rotate;
      req_flip        <= row.grid_cell.flip;
      req_mirror      <= row.grid_cell.mirror;
      req_restart     <= row.grid_cell.restart;
      do @(posedge clock); while (!req_ready);
      n = predict_quad(row.grid_cell);
      // hand-written corners replace the computed ones
      if (row.typed && n == 4) begin
         for (int k = 0; k < 4; k++) begin
            at = vertex_queue.size() - 4 + k;
            vertex_queue[at].pos_x = POS_W'((k & 1) ? row.x1 : row.x0);
            vertex_queue[at].pos_y = POS_W'((k & 2) ? row.y1 : row.y0);
            vertex_queue[at].tex_u = TU_W'(row.u[k]);
            vertex_queue[at].tex_v = TV_W'(row.v[k]);
         end
      end
      @(negedge clock);
   endtask

   // lower valid and sit until the block owes nothing
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (vertex_queue.size() != 0);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      store_reg(idx, data);
      @(negedge clock);
      csr_write <= 1'b0;
      @(negedge clock);
   endtask

   // Writes every register, with junk above the width of the narrower ones, then one undecoded index.
   task automatic apply_setting(int tw, int th, int tpr, int sx, int sy,
                                int base, int color, int texmode);
      hold_until_drained();
      repeat (TAIL_CYCLES) @(negedge clock);
      write_reg(CSR_TILE_WIDTH,    {7'($urandom), 9'(tw)});
      write_reg(CSR_TILE_HEIGHT,   {7'($urandom), 9'(th)});
      write_reg(CSR_TILES_PER_ROW, {3'($urandom), 13'(tpr)});
      write_reg(CSR_SHIFT_X,       {3'($urandom), 13'(sx)});
      write_reg(CSR_SHIFT_Y,       {3'($urandom), 13'(sy)});
      write_reg(CSR_BASE_VERTEX,   16'(base));
      write_reg(CSR_COLOR_SLOT,    16'(color));
      write_reg(CSR_TEXMODE_SLOT,  16'(texmode));
      write_reg(CSR_IDX_FIRST_UNUSED + CSR_IDX_W'($urandom_range(0, 7)), 16'($urandom));
   endtask

   function automatic cell_type mk_cell(int col, int row, int tile,
                                        bit rot, bit flp, bit mir, bit rst);
      cell_type c;
      c.column      = 8'(col);
      c.grid_row    = 8'(row);
      c.tile_number = TILE_W'(tile);
      c.rotate      = rot;
      c.flip        = flp;
      c.mirror      = mir;
      c.restart     = rst;
      return c;
   endfunction

   function automatic void add_plain(cell_type c);
      stim_row_type r;
      r.grid_cell = c;
      r.typed     = 1'b0;
      stim_table  = {stim_table, r};
   endfunction

   function automatic void add_typed(cell_type c, int x0, int x1, int y0, int y1,
                                     int u0, int u1, int u2, int u3,
                                     int v0, int v1, int v2, int v3);
      stim_row_type r;
      r.grid_cell = c;
      r.typed     = 1'b1;
      r.x0 = x0; r.x1 = x1; r.y0 = y0; r.y1 = y1;
      r.u[0] = u0; r.u[1] = u1; r.u[2] = u2; r.u[3] = u3;
      r.v[0] = v0; r.v[1] = v1; r.v[2] = v2; r.v[3] = v3;
      stim_table = {stim_table, r};
   endfunction

   // Tile sizes: mostly small, a few up to the top and past it.
   function automatic int pick_size();
      int r;
      r = $urandom_range(0, 9);
      if (r < 8) return $urandom_range(1, 32);
      if (r == 8) return $urandom_range(1, 256);
      return $urandom_range(0, 511);
   endfunction

   function automatic int pick_tpr();
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) return $urandom_range(1, 24);
      if (r < 9) return $urandom_range(1, 4096);
      return $urandom_range(0, 8191);
   endfunction

   function automatic int pick_shift();
      if ($urandom_range(0, 1)) return -int'($urandom_range(0, 4095));
      return $urandom_range(0, 8191);   // whole 13-bit range, positive values too
   endfunction

   // Random cell; in scan mode the column and row walk the grid like a tilemap pass.
   function automatic stim_row_type random_row(bit scan);
      stim_row_type r;
      int t;
      int tile;
      if (scan) begin
         scan_col = (scan_col + 1) % 256;
         if (scan_col == 0) scan_row = (scan_row + 1) % 256;
         if ($urandom_range(0, 15) == 0) begin
            scan_col = $urandom_range(0, 255);
            scan_row = $urandom_range(0, 255);
         end
      end else begin
         scan_col = $urandom_range(0, 255);
         scan_row = $urandom_range(0, 255);
      end
      t = $urandom_range(0, 19);
      if (t < 3) tile = 0;                           // empty cell
      else if (t < 11) tile = $urandom_range(1, 300);
      else tile = $urandom_range(1, 65535);
      r.grid_cell = mk_cell(scan_col, scan_row, tile,
                            $urandom_range(0, 1), $urandom_range(0, 1),
                            $urandom_range(0, 1), $urandom_range(0, 9) == 0);
      r.typed = 1'b0;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      int items;
      bit scan;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_column      = '0;
      req_grid_row    = '0;
      req_tile_number = '0;
      req_rotate      = 1'b0;
      req_flip        = 1'b0;
      req_mirror      = 1'b0;
      req_restart     = 1'b0;
      rsp_ready       = 1'b1;
      csr_write       = 1'b0;
      csr_index       = '0;
      csr_data        = '0;
      items           = 0;

      // shadow registers at their reset values
      tile_width_r    = TILE_SIZE_RESET;
      tile_height_r   = TILE_SIZE_RESET;
      tiles_per_row_r = TPR_RESET;
      shift_x_r       = '0;
      shift_y_r       = '0;
      base_vertex_r   = '0;
      color_slot_r    = '0;
      texmode_slot_r  = '0;
      vertex_count    = '0;

      // Directed rows, run at the reset settings (16x16 tiles, 16 per atlas row,
      // no shift): one tile is 256 sixteenths wide on screen.
      add_typed(mk_cell(0, 0, 1, 0, 0, 0, 1), 0, 256, 0, 256,
                0, 16, 0, 16, 0, 0, 16, 16);
      add_plain(mk_cell(0, 0, 0, 0, 0, 0, 0));                // empty: nothing out
      // far corner of the grid, last tile number
      add_typed(mk_cell(255, 255, 65535, 0, 0, 0, 0), 65280, 65536, 65280, 65536,
                224, 240, 224, 240, 65520, 65520, 65536, 65536);
      add_typed(mk_cell(0, 0, 1, 0, 0, 1, 0), 0, 256, 0, 256,  // mirror
                16, 0, 16, 0, 0, 0, 16, 16);
      add_typed(mk_cell(0, 0, 1, 0, 1, 0, 0), 0, 256, 0, 256,  // flip
                0, 16, 0, 16, 16, 16, 0, 0);
      add_typed(mk_cell(0, 0, 1, 1, 0, 0, 0), 0, 256, 0, 256,  // rotate
                0, 0, 16, 16, 0, 16, 0, 16);
      add_typed(mk_cell(0, 0, 1, 1, 1, 0, 0), 0, 256, 0, 256,  // rotate + flip
                16, 16, 0, 0, 0, 16, 0, 16);
      add_typed(mk_cell(0, 0, 1, 1, 0, 1, 0), 0, 256, 0, 256,  // rotate + mirror
                0, 0, 16, 16, 16, 0, 16, 0);
      add_plain(mk_cell(3, 7, 5, 1, 1, 1, 0));
      add_plain(mk_cell(9, 2, 40, 0, 1, 1, 0));
      add_plain(mk_cell(12, 12, 0, 0, 0, 0, 1));              // empty cell still reloads
      add_plain(mk_cell(17, 3, 16, 0, 0, 0, 0));              // last atlas column
      add_plain(mk_cell(18, 3, 17, 0, 0, 0, 0));              // wraps to next atlas row
      add_plain(mk_cell(255, 255, 65535, 1, 1, 1, 1));        // every bit set
      add_plain(mk_cell(128, 1, 32768, 0, 0, 0, 0));
      add_plain(mk_cell(85, 170, 21845, 1, 0, 1, 0));
      add_plain(mk_cell(170, 85, 43690, 0, 1, 0, 1));

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (stim_table[i]) begin
         if (i % 6 == 0) calm = ($urandom_range(0, 3) == 0);
         send_cell(stim_table[i]);
      end

      // Random phases; the first four pin the registers at their extremes and
      // out-of-range values, the rest draw them.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: apply_setting(1, 1, 1, -4095, -4095, 16'hFFFD, 16'hFFFF, 16'hFFFF);
            1: apply_setting(256, 256, 4096, 0, 0, 16'hFFFF, 0, 0);
            2: apply_setting(0, 511, 0, 4095, -4096, 16'h8000, 16'hAAAA, 16'h5555);
            3: apply_setting(257, 0, 8191, -1, 4095, 16'hFFF0, 16'h5555, 16'hAAAA);
            default: apply_setting(pick_size(), pick_size(), pick_tpr(), pick_shift(),
                                   pick_shift(), $urandom_range(0, 65535),
                                   $urandom_range(0, 65535), $urandom_range(0, 65535));
         endcase
         scan = p[0];
         for (int i = 0; i < CELLS_PER_PHASE; i++) begin
            if (items % 20 == 0) calm = ($urandom_range(0, 3) == 0);
            send_cell(random_row(scan));
            items++;
            // one full stop mid-run: let the block empty out completely
            if (p == 3 && i == CELLS_PER_PHASE / 2) hold_until_drained();
         end
      end

      hold_until_drained();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (err_count == 0) begin
         $display("tile_quad_vertex_generator verification clean");
      end else begin
         $display("tile_quad_vertex_generator verification failed");
      end
      $finish;
   end

endmodule

[sim.f]
hdl/tqv_pkg.sv
hdl/tqv_div.sv
hdl/tqv_dpath.sv
hdl/tqv_ctrl.sv
hdl/tile_quad_vertex_generator.sv
test/tile_quad_vertex_generator_tb.sv
